// File: rtl/core/adtif_pkg.sv
package adtif_pkg;

  // Default queue depth
  localparam int QUEUE_DEPTH_DEF = 16;

  // Field widths
  localparam int CMD_W       = 2;
  localparam int BYTE_W      = 8;
  localparam int VALUE_W     = 32;
  localparam int COUNT_OUT_W = 5;
  localparam int OUT_W       = VALUE_W + 3 + COUNT_OUT_W + BYTE_W;

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_RX    = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Characters of interest
  localparam logic [BYTE_W-1:0] CHR_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CHR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHR_NOOP  = 8'h6E;

  // Magnitude saturation point (2^31) and positive clamp
  localparam logic [VALUE_W-1:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

  // Parser to top: field completion and command-char latch
  typedef struct packed {
    logic               done;
    logic               latch;
    logic [VALUE_W-1:0] value;
  } field_t;

  // Top to queue: one operation per transfer
  typedef struct packed {
    logic               push;
    logic               pop;
    logic               clear;
    logic [VALUE_W-1:0] wdata;
  } qctl_t;

endpackage

// File: rtl/core/adtif_parse.sv
module adtif_parse (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rx_en,
  input  logic [adtif_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [adtif_pkg::BYTE_W-1:0]   separator,
  output adtif_pkg::field_t              field
);

  typedef enum logic [2:0] {
    PH_SIGN   = 3'b001,
    PH_DIGITS = 3'b010,
    PH_SKIP   = 3'b100
  } phase_t;

  localparam int PROD_W = adtif_pkg::VALUE_W + 4;

  logic [adtif_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  phase_t                        phase_r, phase_nxt;
  logic                          neg_r, neg_nxt;
  logic                          nonempty_r, nonempty_nxt;

  logic                          is_sep, is_digit, is_minus, is_num;
  logic [PROD_W-1:0]             prod;
  logic [adtif_pkg::VALUE_W-1:0] acc_sat;

  // Byte classes
  always_comb begin
    is_sep   = (rx_byte == separator);
    is_digit = rx_byte inside {[adtif_pkg::CHR_ZERO:adtif_pkg::CHR_NINE]};
    is_minus = (rx_byte == adtif_pkg::CHR_MINUS);
    is_num   = is_digit || is_minus || (rx_byte == adtif_pkg::CHR_DOT);
  end

  // acc * 10 + digit, saturated at 2^31
  always_comb begin
    prod = (PROD_W'(acc_r) << 3) + (PROD_W'(acc_r) << 1)
         + PROD_W'(rx_byte - adtif_pkg::CHR_ZERO);
    if (prod > PROD_W'(adtif_pkg::MAG_LIMIT)) begin
      acc_sat = adtif_pkg::MAG_LIMIT;
    end else begin
      acc_sat = prod[adtif_pkg::VALUE_W-1:0];
    end
  end

  // Field value with signed clamp
  always_comb begin
    field.done  = rx_en && is_sep && nonempty_r;
    field.latch = rx_en && !is_sep && !is_num && (rx_byte != adtif_pkg::CHR_NOOP);
    if (neg_r) begin
      field.value = adtif_pkg::VALUE_W'(0) - acc_r;
    end else if (acc_r == adtif_pkg::MAG_LIMIT) begin
      field.value = adtif_pkg::POS_MAX;
    end else begin
      field.value = acc_r;
    end
  end

  // Parse state update
  always_comb begin
    acc_nxt      = acc_r;
    phase_nxt    = phase_r;
    neg_nxt      = neg_r;
    nonempty_nxt = nonempty_r;
    if (rx_en) begin
      if (is_sep) begin
        acc_nxt      = '0;
        phase_nxt    = PH_SIGN;
        neg_nxt      = 1'b0;
        nonempty_nxt = 1'b0;
      end else if (is_num) begin
        nonempty_nxt = 1'b1;
        if ((phase_r == PH_SIGN) && is_minus) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_DIGITS;
        end else if ((phase_r != PH_SKIP) && is_digit) begin
          acc_nxt   = acc_sat;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      phase_r    <= PH_SIGN;
      neg_r      <= 1'b0;
      nonempty_r <= 1'b0;
    end else begin
      acc_r      <= acc_nxt;
      phase_r    <= phase_nxt;
      neg_r      <= neg_nxt;
      nonempty_r <= nonempty_nxt;
    end
  end

endmodule

// File: rtl/core/adtif_queue.sv
module adtif_queue #(
  parameter int QUEUE_DEPTH = adtif_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  adtif_pkg::qctl_t                    ctl,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    count,
  output logic                                full,
  output logic                                empty,
  output logic [adtif_pkg::VALUE_W-1:0]       rd_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [adtif_pkg::VALUE_W-1:0] mem [QUEUE_DEPTH];

  logic [PTR_W-1:0]              rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]              wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [adtif_pkg::VALUE_W-1:0] rd_data_r;

  assign count   = cnt_r;
  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = rd_data_r;

  // Pointer and count update; clear wins
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    if (ctl.clear) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      cnt_nxt    = '0;
    end else if (ctl.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      cnt_nxt    = cnt_r + 1'b1;
    end else if (ctl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      cnt_nxt    = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Value store: one write or one registered read per transfer
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= ctl.wdata;
    end
    if (ctl.pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

endmodule

// File: rtl/core/ascii_decimal_to_int_fifo.sv
// Channel | Direction | tdata                                   | tuser
// in_     | slave     | [7:0] rx_byte                           | [1:0] command
// out_    | master    | [31:0] popped_value, [32] pop_empty,    | -
//         |           | [33] value_pushed, [34] value_dropped,  |
//         |           | [39:35] queue_count, [47:40] command_char|
// cfg_    | write     | cfg_wr_data [7:0] separator             | -
//
// One item per cycle sustained while out_ keeps taking results; a result passes
// through the read stage and then the output register before it shows on out_;
// the read stage covers the registered read of the value store.
// Reset (rst_n low, synchronous) empties the queue, restarts the parser and
// sets separator and command_char to zero; no clearing pass is needed.
// in_tready drops only while both the read stage and the output register
// hold results that out_ has not yet taken.
module ascii_decimal_to_int_fifo #(
  parameter int QUEUE_DEPTH = adtif_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [adtif_pkg::BYTE_W-1:0]   cfg_wr_data,  // separator
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [adtif_pkg::BYTE_W-1:0]   in_tdata,     // [7:0] rx_byte
  input  logic [adtif_pkg::CMD_W-1:0]    in_tuser,     // [1:0] command
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] popped_value, [32] pop_empty, [33] value_pushed,
  // [34] value_dropped, [39:35] queue_count, [47:40] command_char
  output logic [adtif_pkg::OUT_W-1:0]    out_tdata
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic pop_ok;
    logic pop_empty;
    logic pushed;
    logic dropped;
  } flags_t;

  logic                          accept;
  adtif_pkg::cmd_t               cmd;
  logic                          rx_en;
  adtif_pkg::field_t             field;
  adtif_pkg::qctl_t              qctl;
  logic [CNT_W-1:0]              q_count;
  logic                          q_full, q_empty;
  logic [adtif_pkg::VALUE_W-1:0] q_rd_data;

  logic [adtif_pkg::BYTE_W-1:0]  sep_r;
  logic [adtif_pkg::BYTE_W-1:0]  char_r, char_nxt;
  flags_t                        flags_nxt;
  flags_t                        s1_r;
  logic                          s1_v_r, s1_v_nxt;
  logic                          s1_move;
  logic                          out_v_r, out_v_nxt;
  logic [adtif_pkg::OUT_W-1:0]   out_data_r;
  logic [adtif_pkg::VALUE_W-1:0] pop_val;

  // Handshake
  assign s1_move   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_move;
  assign accept    = in_tvalid && in_tready;
  assign cmd       = adtif_pkg::cmd_t'(in_tuser);
  assign rx_en     = accept && (cmd == adtif_pkg::CMD_RX);

  adtif_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_en     (rx_en),
    .rx_byte   (in_tdata),
    .separator (sep_r),
    .field     (field)
  );

  // Queue operation and result flags for this transfer
  always_comb begin
    qctl            = '0;
    flags_nxt       = '0;
    qctl.wdata      = field.value;
    qctl.push       = field.done && !q_full;
    flags_nxt.pushed  = field.done && !q_full;
    flags_nxt.dropped = field.done && q_full;
    if (accept) begin
      case (cmd)
        adtif_pkg::CMD_POP: begin
          qctl.pop            = !q_empty;
          flags_nxt.pop_ok    = !q_empty;
          flags_nxt.pop_empty = q_empty;
        end
        adtif_pkg::CMD_CLEAR: begin
          qctl.clear = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  adtif_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (qctl),
    .count   (q_count),
    .full    (q_full),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  // Command character
  always_comb begin
    char_nxt = char_r;
    if (qctl.clear) begin
      char_nxt = '0;
    end else if (field.latch) begin
      char_nxt = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r  <= '0;
      char_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        sep_r <= cfg_wr_data;
      end
      char_r <= char_nxt;
    end
  end

  // Read stage: queue count, char and read data settle with this entry
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_move) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
    pop_val = s1_r.pop_ok ? q_rd_data : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= flags_nxt;
    end
    if (s1_move) begin
      out_data_r <= {char_r, adtif_pkg::COUNT_OUT_W'(q_count), s1_r.dropped,
                     s1_r.pushed, s1_r.pop_empty, pop_val};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/core/adtif_chk.sv
module adtif_chk #(
  parameter int QUEUE_DEPTH = adtif_pkg::QUEUE_DEPTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [adtif_pkg::OUT_W-1:0]   out_tdata
);

  localparam logic [adtif_pkg::COUNT_OUT_W-1:0] FULL_CNT =
    adtif_pkg::COUNT_OUT_W'(QUEUE_DEPTH);

  logic [adtif_pkg::VALUE_W-1:0]     o_value;
  logic                              o_empty, o_pushed, o_dropped;
  logic [adtif_pkg::COUNT_OUT_W-1:0] o_count;

  assign o_value   = out_tdata[31:0];
  assign o_empty   = out_tdata[32];
  assign o_pushed  = out_tdata[33];
  assign o_dropped = out_tdata[34];
  assign o_count   = out_tdata[39:35];

  // No result right after reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Input stalls only under output backpressure
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("in_tready low without output stall");

  // Flags are exclusive; an empty pop carries zero
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(o_pushed && o_dropped) && !(o_empty && (o_pushed || o_dropped))
                   && !(o_empty && (o_value != '0)))
    else $error("inconsistent result flags");

  // A drop only happens with a full queue
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_dropped |-> o_count == FULL_CNT)
    else $error("drop reported with queue not full");

endmodule

bind ascii_decimal_to_int_fifo adtif_chk #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_adtif_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/adtif_checker.sv
module adtif_checker
  import adtif_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [BYTE_W-1:0]  cfg_wr_data,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [BYTE_W-1:0]  in_tdata,   // [7:0] rx_byte
  input  logic [CMD_W-1:0]   in_tuser,   // [1:0] command
  input  logic               out_tvalid,
  input  logic               out_tready,
  // [31:0] popped_value, [32] pop_empty, [33] value_pushed,
  // [34] value_dropped, [39:35] queue_count, [47:40] command_char
  input  logic [OUT_W-1:0]   out_tdata,
  output int                 fail_count,
  output int                 due_count
);

  localparam int DEPTH     = QUEUE_DEPTH_DEF;
  localparam int REPORT_MAX = 10;

  typedef enum logic [1:0] {
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct {
    logic [VALUE_W-1:0]     value;
    logic                   empty;
    logic                   pushed;
    logic                   dropped;
    logic [COUNT_OUT_W-1:0] count;
    logic [BYTE_W-1:0]      chr;
  } report_t;

  // Mirror of the parser and queue state
  logic [BYTE_W-1:0]  sep;
  logic [VALUE_W-1:0] mag;
  phase_t             phase;
  logic               neg;
  logic               nonempty;
  logic [VALUE_W-1:0] store [DEPTH];
  int                 rd_ptr;
  int                 wr_ptr;
  int                 fill;
  logic [BYTE_W-1:0]  held_char;

  report_t due_reports [$];
  int      mismatches = 0;

  task automatic restart_field();
    mag      = '0;
    phase    = PH_SIGN;
    neg      = 1'b0;
    nonempty = 1'b0;
  endtask

  // Apply one input transfer to the mirror state and build its report
  task automatic parse_step(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                            output report_t r);
    logic        is_digit;
    logic [35:0] wide;
    r        = '{default: '0};
    is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
    case (cmd)
      CMD_RX: begin
        if (b == sep) begin
          // separator wins over '.', '-' and digits
          if (nonempty) begin
            if (fill < DEPTH) begin
              store[wr_ptr] = neg ? -mag : ((mag > POS_MAX) ? POS_MAX : mag);
              wr_ptr        = (wr_ptr + 1) % DEPTH;
              fill++;
              r.pushed = 1'b1;
            end else begin
              r.dropped = 1'b1;
            end
          end
          restart_field();
        end else if (b == CHR_DOT || b == CHR_MINUS || is_digit) begin
          nonempty = 1'b1;
          if (phase == PH_SIGN && b == CHR_MINUS) begin
            neg   = 1'b1;
            phase = PH_DIGITS;
          end else if (phase != PH_DONE && is_digit) begin
            // magnitude saturates at 2^31
            wide  = 36'(mag) * 36'd10 + 36'(b - CHR_ZERO);
            mag   = (wide > 36'(MAG_LIMIT)) ? MAG_LIMIT : wide[VALUE_W-1:0];
            phase = PH_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end else if (b != CHR_NOOP) begin
          held_char = b;
        end
      end
      CMD_POP: begin
        if (fill == 0) begin
          r.empty = 1'b1;
        end else begin
          r.value = store[rd_ptr];
          rd_ptr  = (rd_ptr + 1) % DEPTH;
          fill--;
        end
      end
      CMD_CLEAR: begin
        // parser state is left alone
        rd_ptr    = 0;
        wr_ptr    = 0;
        fill      = 0;
        held_char = '0;
      end
      default: ;
    endcase
    r.count = fill[COUNT_OUT_W-1:0];
    r.chr   = held_char;
  endtask

  task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    report_t want;
    report_t got;
    if (!rst_n) begin
      sep       = '0;
      restart_field();
      rd_ptr    = 0;
      wr_ptr    = 0;
      fill      = 0;
      held_char = '0;
      due_reports.delete();
    end else begin
      if (cfg_wr_en)
        sep = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        got.value   = out_tdata[VALUE_W-1:0];
        got.empty   = out_tdata[VALUE_W];
        got.pushed  = out_tdata[VALUE_W+1];
        got.dropped = out_tdata[VALUE_W+2];
        got.count   = out_tdata[VALUE_W+3 +: COUNT_OUT_W];
        got.chr     = out_tdata[VALUE_W+3+COUNT_OUT_W +: BYTE_W];
        if (due_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result with nothing pending: %h", out_tdata);
        end else begin
          want = due_reports.pop_front();
          check_field("popped_value", want.value, got.value);
          check_field("pop_empty", 32'(want.empty), 32'(got.empty));
          check_field("value_pushed", 32'(want.pushed), 32'(got.pushed));
          check_field("value_dropped", 32'(want.dropped), 32'(got.dropped));
          check_field("queue_count", 32'(want.count), 32'(got.count));
          check_field("command_char", 32'(want.chr), 32'(got.chr));
        end
      end
      if (in_tvalid && in_tready) begin
        parse_step(in_tuser, in_tdata, want);
        due_reports.push_back(want);
      end
    end
    fail_count <= mismatches;
    due_count  <= due_reports.size();
  end

endmodule

// File: tb/tb_ascii_decimal_to_int_fifo.sv
module tb_ascii_decimal_to_int_fifo;
  import adtif_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_wr_en   = 1'b0;
  logic [BYTE_W-1:0]  cfg_wr_data = '0;
  logic               in_tvalid   = 1'b0;
  logic               in_tready;
  logic [BYTE_W-1:0]  in_tdata    = '0;  // [7:0] rx_byte
  logic [CMD_W-1:0]   in_tuser    = '0;  // [1:0] command
  logic               out_tvalid;
  logic               out_tready  = 1'b0;
  // [31:0] popped_value, [32] pop_empty, [33] value_pushed,
  // [34] value_dropped, [39:35] queue_count, [47:40] command_char
  logic [OUT_W-1:0]   out_tdata;

  int fail_count;
  int due_count;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_reqs  = 0;
  int hold_done  = 0;
  int hold_left  = 0;
  int quiet      = 0;
  int sent       = 0;

  always #6 clk = ~clk;

  ascii_decimal_to_int_fifo u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  adtif_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .due_count   (due_count)
  );

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_reqs != hold_done) begin
      hold_done  <= hold_done + 1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(rx_idle_on && $urandom_range(0, 99) < 15);
    end
  end

  // Watchdog: too many cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One input transfer, occasionally preceded by a pause with in_tvalid low
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b);
    if (tx_idle_on && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // Stop sending until every pending result has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_separator(input logic [BYTE_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // A mostly well-formed number field closed by the separator
  task automatic send_field(input logic [BYTE_W-1:0] sep);
    string s;
    int    r;
    int    n;
    if ($urandom_range(0, 99) < 40)
      send_item(CMD_RX, CHR_MINUS);
    r = $urandom_range(0, 99);
    if (r < 6) begin
      // around the saturation point
      case ($urandom_range(0, 3))
        0:       s = "2147483647";
        1:       s = "2147483648";
        2:       s = "2147483649";
        default: s = "4294967296";
      endcase
      for (int i = 0; i < s.len(); i++)
        send_item(CMD_RX, s[i]);
    end else begin
      n = (r < 11) ? 0 : (r < 75) ? $urandom_range(1, 3) :
          (r < 92) ? $urandom_range(4, 9) : $urandom_range(10, 12);
      repeat (n) send_item(CMD_RX, BYTE_W'(CHR_ZERO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 99) < 15) begin
      send_item(CMD_RX, CHR_DOT);
      repeat ($urandom_range(0, 3))
        send_item(CMD_RX, BYTE_W'(CHR_ZERO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 99) < 8)
      send_item(CMD_RX, BYTE_W'($urandom_range(0, 255)));
    send_item(CMD_RX, sep);
  endtask

  task automatic run_phase(input logic [BYTE_W-1:0] sep, input int n_items,
                           input int pop_pct, input int clear_pct, input bit hold_off);
    int start;
    int r;
    set_separator(sep);
    if (hold_off)
      hold_reqs <= hold_reqs + 1;
    start = sent;
    while (sent - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < pop_pct) begin
        send_item(CMD_POP, BYTE_W'($urandom_range(0, 255)));
      end else if (r < pop_pct + clear_pct) begin
        send_item(CMD_CLEAR, BYTE_W'($urandom_range(0, 255)));
      end else if (r < pop_pct + clear_pct + 10) begin
        case ($urandom_range(0, 3))
          0:       send_item(CMD_RX, BYTE_W'($urandom_range(0, 255)));
          1:       send_item(CMD_RX, CHR_NOOP);
          2:       send_item(CMD_SPARE, BYTE_W'($urandom_range(0, 255)));
          default: send_item(CMD_RX, sep);
        endcase
      end else begin
        send_field(sep);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: separator is zero out of reset
    send_item(CMD_RX, "7");
    send_item(CMD_RX, 8'h00);
    set_separator(",");
    send_item(CMD_RX, CHR_MINUS);
    send_item(CMD_RX, "9");
    send_item(CMD_RX, ",");
    send_item(CMD_RX, ",");          // empty field
    send_item(CMD_RX, CHR_MINUS);    // lone minus gives zero
    send_item(CMD_RX, ",");
    send_item(CMD_RX, "1");
    send_item(CMD_RX, CHR_DOT);
    send_item(CMD_RX, "5");
    send_item(CMD_RX, ",");
    send_item(CMD_RX, CHR_NOOP);
    send_item(CMD_RX, "A");
    send_item(CMD_RX, 8'hFF);
    repeat (5) send_item(CMD_POP, 8'h00);  // last one finds the queue empty
    send_item(CMD_SPARE, 8'hA5);
    send_item(CMD_RX, "3");
    send_item(CMD_CLEAR, 8'h5A);     // number being gathered survives
    send_item(CMD_RX, ",");
    send_item(CMD_POP, 8'hFF);

    // Random phases over several separators
    run_phase(",",   90, 20, 2, 1'b0);
    run_phase(8'h00, 80,  0, 0, 1'b0);  // fills the queue, forces drops
    run_phase(8'hFF, 80, 30, 2, 1'b1);  // long result-side hold-off
    run_phase("-",   70, 20, 2, 1'b0);
    run_phase("5",   70, 20, 2, 1'b0);
    run_phase(".",   70, 20, 2, 1'b0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_phase(8'h0A, 80, 25, 2, 1'b0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_phase(" ",   80, 10, 2, 1'b0);

    drain();
    repeat (6) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
